### rtl/hnlp_pkg.sv
// Package for the number literal parser: payload words, parse state and codes.
// Used by hnlp_step, hdl_number_literal_parser_top and the port checker.

package hnlp_pkg;

   // Parse phase of the literal being read
   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_SIZE   = 3'd1,
      PH_QUOTE  = 3'd2,
      PH_SIGN   = 3'd3,
      PH_DIGITS = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   // Radix selection
   typedef enum logic [1:0] {
      RX_BIN = 2'd0,
      RX_OCT = 2'd1,
      RX_DEC = 2'd2,
      RX_HEX = 2'd3
   } radix_code_type;

   // Input word: one character
   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   // Result word: one parsed literal
   typedef struct packed {
      logic               ok;
      logic signed [31:0] value;
      logic [4:0]         radix;
      logic [15:0]        decl_size;
   } rsp_type;

   // Running state of the parser
   typedef struct packed {
      phase_type      phase;
      logic [15:0]    size_acc;
      logic [31:0]    value_acc;
      radix_code_type radix_code;
      logic           unknown_seen;
      logic           failed;
   } parse_state_type;

   localparam logic [15:0] SIZE_DEFAULT = 16'd32;
   localparam logic [4:0]  RADIX_DEFAULT = 5'd10;

   localparam parse_state_type STATE_RESET = '{
      phase:        PH_START,
      size_acc:     16'd0,
      value_acc:    32'd0,
      radix_code:   RX_DEC,
      unknown_seen: 1'b0,
      failed:       1'b0
   };

endpackage

### rtl/hnlp_step.sv
// One character step of the literal parser: next parse state and result word.
// Depends on hnlp_pkg; pure combinational logic.

module hnlp_step (
   input  hnlp_pkg::parse_state_type cur_state,
   input  hnlp_pkg::req_type         req_word,
   output hnlp_pkg::parse_state_type next_state,
   output hnlp_pkg::rsp_type         rsp_word
);

   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_S  = 8'h73;
   localparam logic [7:0] CH_UP_S  = 8'h53;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_UP_B  = 8'h42;
   localparam logic [7:0] CH_LO_O  = 8'h6F;
   localparam logic [7:0] CH_UP_O  = 8'h4F;
   localparam logic [7:0] CH_LO_D  = 8'h64;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_LO_H  = 8'h68;
   localparam logic [7:0] CH_UP_H  = 8'h48;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [4:0] NO_DIGIT = 5'd16;

   // Map radix code to base
   function automatic logic [4:0] radix_of(hnlp_pkg::radix_code_type rc);
      logic [4:0] r;
      case (rc)
         hnlp_pkg::RX_BIN: r = 5'd2;
         hnlp_pkg::RX_OCT: r = 5'd8;
         hnlp_pkg::RX_DEC: r = 5'd10;
         default:          r = 5'd16;
      endcase
      return r;
   endfunction

   // Hex digit value of a character, NO_DIGIT if none
   function automatic logic [4:0] hex_value(logic [7:0] c);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = 5'(c - CH_ZERO);
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         d = 5'(c - CH_LO_A + 8'd10);
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         d = 5'(c - CH_UP_A + 8'd10);
      end
      return d;
   endfunction

   // Fold one digit character into the value; skip an underscore, mark an unknown digit, stop on any other non-digit
   function automatic hnlp_pkg::parse_state_type digit_apply(
      hnlp_pkg::parse_state_type st, logic [7:0] c);
      hnlp_pkg::parse_state_type ns;
      logic [4:0]  rad;
      logic [4:0]  d;
      logic [31:0] dz;
      ns  = st;
      rad = radix_of(st.radix_code);
      d   = hex_value(c);
      dz  = {27'd0, d};
      if (c == CH_UNDER) begin
         ns = st;
      end else if (c == CH_LO_X || c == CH_UP_X || c == CH_LO_Z || c == CH_UP_Z ||
                   c == CH_QMARK) begin
         ns.unknown_seen = 1'b1;
         ns.value_acc    = st.value_acc << 4;
      end else if (d >= rad) begin
         ns.phase = hnlp_pkg::PH_DONE;
      end else begin
         case (st.radix_code)
            hnlp_pkg::RX_BIN: ns.value_acc = (st.value_acc << 1) + dz;
            hnlp_pkg::RX_OCT: ns.value_acc = (st.value_acc << 3) + dz;
            hnlp_pkg::RX_DEC: ns.value_acc = (st.value_acc << 3) + (st.value_acc << 1) + dz;
            default:          ns.value_acc = (st.value_acc << 4) + dz;
         endcase
      end
      return ns;
   endfunction

   // Radix letter, or fall into decimal digits
   function automatic hnlp_pkg::parse_state_type radix_apply(
      hnlp_pkg::parse_state_type st, logic [7:0] c);
      hnlp_pkg::parse_state_type ns;
      ns       = st;
      ns.phase = hnlp_pkg::PH_DIGITS;
      if (c == CH_LO_B || c == CH_UP_B) begin
         ns.radix_code = hnlp_pkg::RX_BIN;
      end else if (c == CH_LO_O || c == CH_UP_O) begin
         ns.radix_code = hnlp_pkg::RX_OCT;
      end else if (c == CH_LO_D || c == CH_UP_D) begin
         ns.radix_code = hnlp_pkg::RX_DEC;
      end else if (c == CH_LO_H || c == CH_UP_H) begin
         ns.radix_code = hnlp_pkg::RX_HEX;
      end else begin
         ns.radix_code = hnlp_pkg::RX_DEC;
         ns = digit_apply(ns, c);
      end
      return ns;
   endfunction

   logic [7:0]                c;
   logic                      is_dec;
   logic [19:0]               size_wide;
   logic                      ok;
   hnlp_pkg::parse_state_type upd;

   assign c      = req_word.char_code;
   assign is_dec = (c >= CH_ZERO) && (c <= CH_NINE);

   // Size times ten plus digit, before saturation
   assign size_wide = ({4'd0, cur_state.size_acc} << 3) + ({4'd0, cur_state.size_acc} << 1)
                    + {12'd0, 8'(c - CH_ZERO)};

   // Advance the parse state by one character
   always @(*) begin
      upd = cur_state;
      if (!cur_state.failed) begin
         case (cur_state.phase)
            hnlp_pkg::PH_START, hnlp_pkg::PH_SIZE: begin
               if (is_dec) begin
                  upd.size_acc = (size_wide > 20'd65535) ? 16'hFFFF : size_wide[15:0];
                  upd.phase    = hnlp_pkg::PH_SIZE;
               end else if (c == CH_QUOTE) begin
                  if (cur_state.phase == hnlp_pkg::PH_START) begin
                     upd.size_acc = hnlp_pkg::SIZE_DEFAULT;
                     upd.phase    = hnlp_pkg::PH_QUOTE;
                  end else if (cur_state.size_acc == 16'd0) begin
                     upd.failed = 1'b1;
                  end else begin
                     upd.phase = hnlp_pkg::PH_QUOTE;
                  end
               end else begin
                  upd.failed = 1'b1;
               end
            end
            hnlp_pkg::PH_QUOTE: begin
               if (c == CH_LO_S || c == CH_UP_S) begin
                  upd.phase = hnlp_pkg::PH_SIGN;
               end else begin
                  upd = radix_apply(cur_state, c);
               end
            end
            hnlp_pkg::PH_SIGN:   upd = radix_apply(cur_state, c);
            hnlp_pkg::PH_DIGITS: upd = digit_apply(cur_state, c);
            default:             upd = cur_state;
         endcase
      end
   end

   // Form the result word from the updated state
   assign ok = !upd.failed && (upd.phase == hnlp_pkg::PH_QUOTE ||
               upd.phase == hnlp_pkg::PH_SIGN || upd.phase == hnlp_pkg::PH_DIGITS ||
               upd.phase == hnlp_pkg::PH_DONE);

   always @(*) begin
      if (ok) begin
         rsp_word.ok        = 1'b1;
         rsp_word.value     = upd.unknown_seen ? 32'sd0 : $signed(upd.value_acc);
         rsp_word.radix     = radix_of(upd.radix_code);
         rsp_word.decl_size = upd.size_acc;
      end else begin
         rsp_word.ok        = 1'b0;
         rsp_word.value     = 32'sd0;
         rsp_word.radix     = hnlp_pkg::RADIX_DEFAULT;
         rsp_word.decl_size = 16'd0;
      end
   end

   // Start over after the last character
   assign next_state = req_word.last_char ? hnlp_pkg::STATE_RESET : upd;

endmodule

### rtl/hdl_number_literal_parser_top.sv
// Top level of the based number literal parser: input register, step logic, result register.
// Depends on hnlp_pkg and hnlp_step.
//
//   channel | ports                          | word
//   --------+--------------------------------+-------------------------------
//   input   | req_valid, req_ready, req_data | one character, last flag
//   result  | rsp_valid, rsp_ready, rsp_data | ok, value, radix, decl_size
//
// One character per cycle sustained, except while a last character waits on a stalled
// result; rsp_valid follows the last character through the input and result registers.
// The parse state is updated by the combinational hnlp_step, so characters
// follow each other back to back.
// Reset (synchronous) empties both registers and returns the parse state to start.
// While a result waits, the input register still takes a word; a last character
// then holds in it until the result register frees.

module hdl_number_literal_parser_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hnlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hnlp_pkg::rsp_type rsp_data
);

   logic                      in_valid_ff;
   logic                      in_valid_in;
   hnlp_pkg::req_type         in_word_ff;
   hnlp_pkg::parse_state_type state_ff;
   hnlp_pkg::parse_state_type state_in;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   hnlp_pkg::rsp_type         out_word_ff;
   hnlp_pkg::parse_state_type step_state;
   hnlp_pkg::rsp_type         step_rsp;
   logic                      advance;
   logic                      load_out;

   hnlp_step u_step (
      .cur_state  (state_ff),
      .req_word   (in_word_ff),
      .next_state (step_state),
      .rsp_word   (step_rsp)
   );

   // Advance the held word unless its result has nowhere to go
   assign advance   = in_valid_ff && (!in_word_ff.last_char || !out_valid_ff || rsp_ready);
   assign load_out  = advance && in_word_ff.last_char;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign state_in     = advance ? step_state : state_ff;
   assign out_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // Control registers
   always @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hnlp_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: capture on accept, load result on last character
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (load_out) begin
         out_word_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

### rtl/hnlp_port_check.sv
// Port checker for the literal parser result channel, bound to the top level.
// Depends on hnlp_pkg and hdl_number_literal_parser_top.

module hnlp_port_check (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hnlp_pkg::rsp_type rsp_data
);

   // Stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Failed parse reports a cleared word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |->
         rsp_data.value == 32'sd0 && rsp_data.decl_size == 16'd0 &&
         rsp_data.radix == hnlp_pkg::RADIX_DEFAULT)
      else $error("failed parse word not cleared");

   // Radix is one of the four bases
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.radix == 5'd2 || rsp_data.radix == 5'd8 ||
                    rsp_data.radix == 5'd10 || rsp_data.radix == 5'd16)
      else $error("radix out of set");

   // Good parse never reports size zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ok |-> rsp_data.decl_size != 16'd0)
      else $error("good parse with zero size");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hdl_number_literal_parser_top hnlp_port_check u_port_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### dv/hdl_number_literal_parser_top_tb.sv
// Testbench for hdl_number_literal_parser_top: sends literal text one character per word
// and checks every parsed result against a predictor kept in the bench.
// Depends on hnlp_pkg and the parser RTL.

module hdl_number_literal_parser_top_tb;

   localparam int          LIMIT_CYCLES  = 1000000;
   localparam int          RANDOM_WORDS  = 1100;
   localparam int          HOLD_CYCLES   = 200;
   localparam int          SETTLE_CYCLES = 8;
   localparam logic [7:0]  CH_QUOTE      = 8'h27;
   localparam logic [7:0]  CH_UNDER      = 8'h5F;
   localparam logic [7:0]  UNKNOWN_CHARS [0:4] = '{"x", "X", "z", "Z", "?"};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid;
   logic              req_ready;
   hnlp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   hnlp_pkg::rsp_type rsp_data;

   // parser state mirrored in the bench
   hnlp_pkg::phase_type      lit_phase;
   logic [15:0]              lit_size;
   logic [31:0]              lit_value;
   hnlp_pkg::radix_code_type lit_radix;
   logic                     lit_unknown;
   logic                     lit_failed;

   hnlp_pkg::rsp_type parsed_q[$];
   int      err_count   = 0;
   int      cycle_count = 0;
   int      sent_words  = 0;
   bit      no_idle     = 1'b0;
   int      hold_token  = 0;

   hdl_number_literal_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [4:0] base_of(hnlp_pkg::radix_code_type r);
      case (r)
         hnlp_pkg::RX_BIN:  return 5'd2;
         hnlp_pkg::RX_OCT:  return 5'd8;
         hnlp_pkg::RX_DEC:  return 5'd10;
         default:           return 5'd16;
      endcase
   endfunction

   // digit value of c in the given base, 16 when c is no digit of it
   function automatic logic [4:0] digit_value(logic [7:0] c, logic [4:0] base);
      logic [4:0] d;
      d = 5'd16;
      if (c >= "0" && c <= "9") d = 5'(c - 8'h30);
      else if (c >= "a" && c <= "f") d = 5'(c - 8'h61 + 8'd10);
      else if (c >= "A" && c <= "F") d = 5'(c - 8'h41 + 8'd10);
      return (d < base) ? d : 5'd16;
   endfunction

   task automatic clear_literal();
      lit_phase   = hnlp_pkg::PH_START;
      lit_size    = 16'd0;
      lit_value   = 32'd0;
      lit_radix   = hnlp_pkg::RX_DEC;
      lit_unknown = 1'b0;
      lit_failed  = 1'b0;
   endtask

   task automatic take_digit(logic [7:0] c);
      logic [4:0] base;
      logic [4:0] d;
      base = base_of(lit_radix);
      if (c == CH_UNDER) return;
      if (c == "x" || c == "X" || c == "z" || c == "Z" || c == "?") begin
         lit_unknown = 1'b1;
         lit_value   = lit_value << 4;
         return;
      end
      d = digit_value(c, base);
      if (d == 5'd16) lit_phase = hnlp_pkg::PH_DONE;
      else lit_value = lit_value * {27'd0, base} + {27'd0, d};
   endtask

   // radix letter, or the first digit of a decimal literal
   task automatic take_radix(logic [7:0] c);
      lit_phase = hnlp_pkg::PH_DIGITS;
      if (c == "b" || c == "B") lit_radix = hnlp_pkg::RX_BIN;
      else if (c == "o" || c == "O") lit_radix = hnlp_pkg::RX_OCT;
      else if (c == "d" || c == "D") lit_radix = hnlp_pkg::RX_DEC;
      else if (c == "h" || c == "H") lit_radix = hnlp_pkg::RX_HEX;
      else begin
         lit_radix = hnlp_pkg::RX_DEC;
         take_digit(c);
      end
   endtask

   // advance the parser by one accepted word; queue a result on the last character
   task automatic parse_word(logic [7:0] c, logic last);
      logic [31:0]       grown;
      hnlp_pkg::rsp_type result;
      if (!lit_failed) begin
         case (lit_phase)
            hnlp_pkg::PH_START, hnlp_pkg::PH_SIZE: begin
               if (c >= "0" && c <= "9") begin
                  grown     = {16'd0, lit_size} * 32'd10 + {24'd0, c} - 32'd48;
                  lit_size  = (grown > 32'd65535) ? 16'hFFFF : grown[15:0];
                  lit_phase = hnlp_pkg::PH_SIZE;
               end else if (c == CH_QUOTE) begin
                  if (lit_phase == hnlp_pkg::PH_START) begin
                     lit_size  = hnlp_pkg::SIZE_DEFAULT;
                     lit_phase = hnlp_pkg::PH_QUOTE;
                  end else if (lit_size == 16'd0) begin
                     lit_failed = 1'b1;
                  end else begin
                     lit_phase = hnlp_pkg::PH_QUOTE;
                  end
               end else begin
                  lit_failed = 1'b1;
               end
            end
            hnlp_pkg::PH_QUOTE: begin
               if (c == "s" || c == "S") lit_phase = hnlp_pkg::PH_SIGN;
               else take_radix(c);
            end
            hnlp_pkg::PH_SIGN:   take_radix(c);
            hnlp_pkg::PH_DIGITS: take_digit(c);
            default: ;
         endcase
      end
      if (!last) return;
      if (!lit_failed && lit_phase >= hnlp_pkg::PH_QUOTE) begin
         result.ok        = 1'b1;
         result.value     = lit_unknown ? 32'd0 : lit_value;
         result.radix     = base_of(lit_radix);
         result.decl_size = lit_size;
      end else begin
         result.ok        = 1'b0;
         result.value     = 32'd0;
         result.radix     = hnlp_pkg::RADIX_DEFAULT;
         result.decl_size = 16'd0;
      end
      parsed_q.push_back(result);
      clear_literal();
   endtask

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      err_count++;
      if (err_count <= 30)
         $display("mismatch %s: expected %0h, got %0h", what, want, got);
   endtask

   // offer one word after an optional gap; valid stays high after acceptance
   task automatic send_word(logic [7:0] c, logic last);
      int gap;
      gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data.char_code <= c;
      req_data.last_char <= last;
      do @(posedge clock); while (!req_ready);
      sent_words++;
      parse_word(c, last);
   endtask

   task automatic send_literal(logic [7:0] lit[$]);
      foreach (lit[i]) send_word(lit[i], i == lit.size() - 1);
   endtask

   task automatic send_text(string s);
      logic [7:0] lit[$];
      for (int i = 0; i < s.len(); i++) lit.push_back(s[i]);
      send_literal(lit);
   endtask

   // drop valid and wait for every queued result
   task automatic wait_all_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (parsed_q.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed literals with random content, the rest raw bytes
   task automatic send_random_literal();
      logic [7:0] lit[$];
      logic [7:0] letter;
      logic [4:0] base;
      int         r;
      int         v;
      if ($urandom_range(0, 9) < 8) begin
         case ($urandom_range(0, 9))
            0, 1: ;
            2: begin
               lit.push_back("0");
               if ($urandom_range(0, 1) != 0) lit.push_back("0");
            end
            3: repeat ($urandom_range(5, 7)) lit.push_back(8'(8'h30 + $urandom_range(0, 9)));
            default: repeat ($urandom_range(1, 3)) lit.push_back(8'(8'h30 + $urandom_range(0, 9)));
         endcase
         lit.push_back(CH_QUOTE);
         if ($urandom_range(0, 3) == 0) lit.push_back(($urandom_range(0, 1) != 0) ? "s" : "S");
         base = 5'd10;
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 3))
               0: begin letter = "b"; base = 5'd2;  end
               1: begin letter = "o"; base = 5'd8;  end
               2: begin letter = "d"; base = 5'd10; end
               default: begin letter = "h"; base = 5'd16; end
            endcase
            if ($urandom_range(0, 1) != 0) letter = letter - 8'h20;
            lit.push_back(letter);
         end
         repeat ($urandom_range(0, 10)) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
               v = $urandom_range(0, base - 1);
               if (v < 10) lit.push_back(8'(8'h30 + v));
               else if ($urandom_range(0, 1) != 0) lit.push_back(8'(8'h61 + v - 10));
               else lit.push_back(8'(8'h41 + v - 10));
            end else if (r < 92) begin
               lit.push_back(CH_UNDER);
            end else begin
               lit.push_back(UNKNOWN_CHARS[$urandom_range(0, 4)]);
            end
         end
         // trailing characters past the end of the digits
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) lit.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 6)) lit.push_back(8'($urandom_range(0, 255)));
      end
      send_literal(lit);
   endtask

   task automatic test_radixes();
      send_text("8'hF");
      send_text("'b1");
      send_text("4'O7");
      send_text("'sD9");
      wait_all_results();
   endtask

   task automatic test_special_cases();
      send_text("0'd1");      // size of zero
      send_text("70000'S5");  // saturated size, sign, default radix
      send_text("9'b1_0");    // underscore among digits
      send_text("7'o79");     // digits end at a non-octal character
      send_text("'hAx");      // unknown digit
      send_text("5");         // ends before its quote
      send_literal('{CH_QUOTE, 8'h00, 8'hFF});
      send_literal('{8'hFF});
      wait_all_results();
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (40) send_random_literal();
      wait_all_results();
      no_idle = 1'b0;
   endtask

   // hold the result side off while characters keep coming
   task automatic test_output_stall();
      hold_token++;
      repeat (30) send_random_literal();
      wait_all_results();
   endtask

   task automatic test_random();
      int start;
      start = sent_words;
      while (sent_words - start < RANDOM_WORDS) send_random_literal();
      wait_all_results();
   endtask

   // result side ready with random stalls
   always @(posedge clock) begin : drive_ready
      int idle_left;
      int hold_seen;
      if (reset) begin
         rsp_ready <= 1'b0;
         idle_left = 0;
         hold_seen = 0;
      end else begin
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            idle_left = HOLD_CYCLES;
         end
         if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) idle_left = pick_gap();
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_result
      hnlp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parsed_q.size() == 0) begin
            report_mismatch("word with nothing queued", 32'd0, rsp_data.value);
         end else begin
            want = parsed_q.pop_front();
            if (rsp_data.ok != want.ok)
               report_mismatch("ok", 32'(want.ok), 32'(rsp_data.ok));
            if (rsp_data.value != want.value)
               report_mismatch("value", want.value, rsp_data.value);
            if (rsp_data.radix != want.radix)
               report_mismatch("radix", 32'(want.radix), 32'(rsp_data.radix));
            if (rsp_data.decl_size != want.decl_size)
               report_mismatch("decl_size", 32'(want.decl_size), 32'(rsp_data.decl_size));
         end
      end
   end

   // end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      clear_literal();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_radixes();
      test_special_cases();
      test_back_to_back();
      test_output_stall();
      test_random();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
